>>> sv/epoch_seconds_to_calendar_date_macros.svh
// Assertion macros shared by the epoch-to-calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/esc_pkg.sv
// Constants and the month table for the epoch-to-calendar converter.
`timescale 1ns / 1ps

package esc_pkg;

  // Number of register stages in the conversion pipeline.
  localparam int unsigned NumStages = 9;

  // Day split: seconds * DayRecip >> 32 underestimates by at most one day.
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned DayRecip   = 49710;

  // Hour split: remainder * HourRecip >> 22 underestimates by at most one.
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned HourRecip   = 1165;

  // Minute split: remainder * MinRecip >> 12 underestimates by at most one.
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned MinRecip   = 68;

  // Four-year cycles counted from 1968-01-01, a leap year.
  localparam int unsigned DaysPerCycle = 1461;
  localparam int unsigned CycleRecip   = 1435;
  localparam int unsigned EpochOffset  = 731;
  localparam int unsigned BaseYear     = 1968;

  // Year boundaries inside one cycle: leap year first, then three common years.
  localparam int unsigned Year1Start = 366;
  localparam int unsigned Year2Start = 731;
  localparam int unsigned Year3Start = 1096;

  // Days since 1970 of 2100-03-01. The year 2100 is not leap, so from this
  // day on one day is inserted to keep the four-year cycle regular.
  localparam int unsigned SkipDay = 47541;

  // First day of the year of month idx (0 is January).
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    begin
      case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

>>> sv/epoch_seconds_to_calendar_date.sv
// Top level of the epoch-seconds to Gregorian date and time converter.
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute and second. The converter is a nine-stage
// pipeline: it accepts one transfer per clock cycle unless the output side
// stalls. The rate is set by the pipeline itself; its stages hold constant
// multiplies, compares and subtracts with a single correction step. Every
// stage has its own valid bit and only holds when its successor is full, so
// empty slots are filled while the output waits. No clearing is needed after
// reset.
module epoch_seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] cal_year_o,
  output logic [3:0]  cal_month_o,
  output logic [4:0]  cal_day_o,
  output logic [4:0]  cal_hour_o,
  output logic [5:0]  cal_minute_o,
  output logic [5:0]  cal_second_o
);

  `include "epoch_seconds_to_calendar_date_macros.svh"

  localparam int unsigned Last = esc_pkg::NumStages - 1;

  // Stage valid bits and advance enables.
  logic [esc_pkg::NumStages-1:0] valid_q;
  logic [esc_pkg::NumStages-1:0] stage_en;

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    stage_en[Last] = !valid_q[Last] || out_ready_i;
    for (int k = Last - 1; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[Last];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < esc_pkg::NumStages; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: estimate of whole days by reciprocal multiply.
  logic [47:0] s1_prod;
  logic [31:0] s1_secs_q;
  logic [15:0] s1_dq_q;

  assign s1_prod = 48'(epoch_seconds_i) * 48'(esc_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_secs_q <= epoch_seconds_i;
      s1_dq_q   <= s1_prod[47:32];
    end
  end

  // Stage 2: seconds covered by the day estimate.
  logic [31:0] s2_secs_q;
  logic [15:0] s2_dq_q;
  logic [31:0] s2_pm_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s2_secs_q <= s1_secs_q;
      s2_dq_q   <= s1_dq_q;
      s2_pm_q   <= 32'(s1_dq_q) * 32'(esc_pkg::SecsPerDay);
    end
  end

  // Stage 3: remainder and one correction step give days and time of day.
  logic [31:0] s3_r0;
  logic [15:0] s3_days_d;
  logic [16:0] s3_rem_d;
  logic [15:0] s3_days_q;
  logic [16:0] s3_rem_q;

  always_comb begin
    s3_r0 = s2_secs_q - s2_pm_q;
    if (s3_r0[17:0] >= 18'(esc_pkg::SecsPerDay)) begin
      s3_days_d = s2_dq_q + 16'd1;
      s3_rem_d  = 17'(s3_r0[17:0] - 18'(esc_pkg::SecsPerDay));
    end else begin
      s3_days_d = s2_dq_q;
      s3_rem_d  = s3_r0[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s3_days_q <= s3_days_d;
      s3_rem_q  <= s3_rem_d;
    end
  end

  // Stage 4: day count from 1968 with the missing leap day of 2100 inserted,
  // and the hour estimate.
  logic        s4_skip;
  logic [27:0] s4_hprod;
  logic [15:0] s4_dd_q;
  logic [4:0]  s4_hest_q;
  logic [16:0] s4_rem_q;

  assign s4_skip  = (s3_days_q >= 16'(esc_pkg::SkipDay));
  assign s4_hprod = 28'(s3_rem_q) * 28'(esc_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s4_dd_q   <= s3_days_q + 16'(esc_pkg::EpochOffset) + {15'd0, s4_skip};
      s4_hest_q <= s4_hprod[26:22];
      s4_rem_q  <= s3_rem_q;
    end
  end

  // Stage 5: four-year cycle estimate and seconds covered by the hour estimate.
  logic [26:0] s5_cprod;
  logic [5:0]  s5_cq_q;
  logic [15:0] s5_dd_q;
  logic [16:0] s5_hm_q;
  logic [4:0]  s5_hest_q;
  logic [16:0] s5_rem_q;

  assign s5_cprod = 27'(s4_dd_q) * 27'(esc_pkg::CycleRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s5_cq_q   <= s5_cprod[26:21];
      s5_dd_q   <= s4_dd_q;
      s5_hm_q   <= 17'(s4_hest_q) * 17'(esc_pkg::SecsPerHour);
      s5_hest_q <= s4_hest_q;
      s5_rem_q  <= s4_rem_q;
    end
  end

  // Stage 6: days covered by the cycle estimate; hour correction.
  logic [16:0] s6_r1;
  logic [4:0]  s6_hour_d;
  logic [11:0] s6_r2_d;
  logic [15:0] s6_cm_q;
  logic [5:0]  s6_cq_q;
  logic [15:0] s6_dd_q;
  logic [4:0]  s6_hour_q;
  logic [11:0] s6_r2_q;

  always_comb begin
    s6_r1 = s5_rem_q - s5_hm_q;
    if (s6_r1 >= 17'(esc_pkg::SecsPerHour)) begin
      s6_hour_d = s5_hest_q + 5'd1;
      s6_r2_d   = 12'(s6_r1 - 17'(esc_pkg::SecsPerHour));
    end else begin
      s6_hour_d = s5_hest_q;
      s6_r2_d   = s6_r1[11:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s6_cm_q   <= 16'(s5_cq_q) * 16'(esc_pkg::DaysPerCycle);
      s6_cq_q   <= s5_cq_q;
      s6_dd_q   <= s5_dd_q;
      s6_hour_q <= s6_hour_d;
      s6_r2_q   <= s6_r2_d;
    end
  end

  // Stage 7: cycle correction and the minute estimate.
  logic [15:0] s7_roff;
  logic [5:0]  s7_cyc_d;
  logic [10:0] s7_off_d;
  logic [17:0] s7_mprod;
  logic [5:0]  s7_cyc_q;
  logic [10:0] s7_off_q;
  logic [4:0]  s7_hour_q;
  logic [11:0] s7_r2_q;
  logic [5:0]  s7_mest_q;

  always_comb begin
    s7_roff = s6_dd_q - s6_cm_q;
    if (s7_roff >= 16'(esc_pkg::DaysPerCycle)) begin
      s7_cyc_d = s6_cq_q + 6'd1;
      s7_off_d = 11'(s7_roff - 16'(esc_pkg::DaysPerCycle));
    end else begin
      s7_cyc_d = s6_cq_q;
      s7_off_d = s7_roff[10:0];
    end
  end

  assign s7_mprod = 18'(s6_r2_q) * 18'(esc_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      s7_cyc_q  <= s7_cyc_d;
      s7_off_q  <= s7_off_d;
      s7_hour_q <= s6_hour_q;
      s7_r2_q   <= s6_r2_q;
      s7_mest_q <= s7_mprod[17:12];
    end
  end

  // Stage 8: year within the cycle, day of year and seconds of the minutes.
  logic [1:0]  s8_y4;
  logic [10:0] s8_base;
  logic [11:0] s8_year_q;
  logic        s8_leap_q;
  logic [8:0]  s8_doy_q;
  logic [4:0]  s8_hour_q;
  logic [11:0] s8_r2_q;
  logic [5:0]  s8_mest_q;
  logic [11:0] s8_mm_q;

  always_comb begin
    if (s7_off_q >= 11'(esc_pkg::Year3Start)) begin
      s8_y4   = 2'd3;
      s8_base = 11'(esc_pkg::Year3Start);
    end else if (s7_off_q >= 11'(esc_pkg::Year2Start)) begin
      s8_y4   = 2'd2;
      s8_base = 11'(esc_pkg::Year2Start);
    end else if (s7_off_q >= 11'(esc_pkg::Year1Start)) begin
      s8_y4   = 2'd1;
      s8_base = 11'(esc_pkg::Year1Start);
    end else begin
      s8_y4   = 2'd0;
      s8_base = 11'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      s8_year_q <= 12'(esc_pkg::BaseYear) + {4'd0, s7_cyc_q, 2'b00} + {10'd0, s8_y4};
      s8_leap_q <= (s8_y4 == 2'd0);
      s8_doy_q  <= 9'(s7_off_q - s8_base);
      s8_hour_q <= s7_hour_q;
      s8_r2_q   <= s7_r2_q;
      s8_mest_q <= s7_mest_q;
      s8_mm_q   <= 12'(s7_mest_q) * 12'(esc_pkg::SecsPerMin);
    end
  end

  // Stage 9: month walk over the table and minute correction.
  logic [3:0]  s9_midx;
  logic [8:0]  s9_start;
  logic [11:0] s9_r3;
  logic [5:0]  s9_minute_d;
  logic [5:0]  s9_second_d;

  always_comb begin
    s9_midx  = 4'd0;
    s9_start = 9'd0;
    for (int k = 1; k < 12; k++) begin
      if (s8_doy_q >= esc_pkg::month_start(s8_leap_q, 4'(k))) begin
        s9_midx  = 4'(k);
        s9_start = esc_pkg::month_start(s8_leap_q, 4'(k));
      end
    end
  end

  always_comb begin
    s9_r3 = s8_r2_q - s8_mm_q;
    if (s9_r3 >= 12'(esc_pkg::SecsPerMin)) begin
      s9_minute_d = s8_mest_q + 6'd1;
      s9_second_d = 6'(s9_r3 - 12'(esc_pkg::SecsPerMin));
    end else begin
      s9_minute_d = s8_mest_q;
      s9_second_d = s9_r3[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[8]) begin
      cal_year_o   <= s8_year_q;
      cal_month_o  <= s9_midx + 4'd1;
      cal_day_o    <= 5'(s8_doy_q - s9_start) + 5'd1;
      cal_hour_o   <= s8_hour_q;
      cal_minute_o <= s9_minute_d;
      cal_second_o <= s9_second_d;
    end
  end

  // Checks on the pipeline control and the result ranges.
  `ESC_ASSERT_NOW(a_stall_from_output, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while output side is free")
  `ESC_ASSERT_NOW(a_date_range, out_valid_o, cal_month_o >= 4'd1 && cal_month_o <= 4'd12 && cal_day_o >= 5'd1, "month or day out of range")
  `ESC_ASSERT_NOW(a_time_range, out_valid_o, cal_hour_o <= 5'd23 && cal_minute_o <= 6'd59 && cal_second_o <= 6'd59, "time of day out of range")
  `ESC_ASSERT_NEXT(a_full_pipe_holds, (&valid_q) && !out_ready_i, &valid_q, "full pipeline lost a transfer while stalled")

endmodule
